// File: src/art_pkg.sv
// shared types and constants of the ack retransmit tracker
package art_pkg;

  localparam int TableDepthDefault = 16;
  localparam int MaxResults        = 16;
  localparam int ResCntW           = $clog2(MaxResults + 1);
  localparam int TypeW             = 8;
  localparam int StampW            = 64;
  localparam int PeerW             = 48;
  localparam int AgeW              = 16;
  localparam int SlotW             = 4;

  localparam logic [AgeW-1:0] IntervalReset = 16'd20;
  localparam logic [AgeW-1:0] AgeMax        = 16'hFFFF;

  typedef enum logic [1:0] {
    ReqSend = 2'd0,
    ReqAck  = 2'd1,
    ReqTick = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    EvStored  = 3'd0,
    EvFull    = 3'd1,
    EvMatched = 3'd2,
    EvMissed  = 3'd3,
    EvResend  = 3'd4
  } event_e;

  typedef struct packed {
    logic [TypeW-1:0]  ptype;
    logic [StampW-1:0] stamp;
    logic [PeerW-1:0]  peer;
    logic [AgeW-1:0]   age;
  } entry_t;

  typedef struct packed {
    event_e            kind;
    logic [TypeW-1:0]  ptype;
    logic [StampW-1:0] stamp;
    logic [PeerW-1:0]  peer;
    logic [SlotW-1:0]  slot;
    logic              last;
  } result_t;

endpackage

// File: src/ack_retransmit_tracker_core.sv
// ack retransmit tracker: table of unacknowledged sends, ack search and tick aging
//
// Keeps up to TableDepth sent packets (type, 64-bit stamp, 48-bit peer, age) in
// insertion order in a single-port-read, single-port-write table memory, walked
// one entry per cycle by a small sequencer unless a result waits for the output.
// A send yields one request on the output (stored, or table full). An ack searches
// for the first match and then shifts the later entries down; it yields one
// request. A tick yields one resend request for every entry whose age reaches
// resend_interval, at most 16 per tick, the final one flagged by last_o. The table
// read port reads one entry per cycle. The input is stalled while an item is in
// progress; the output register lets a finished request wait for the consumer
// while the block takes the next item. Further output back-pressure holds the
// sequencer. The interval register may only be written while the block is idle.
module ack_retransmit_tracker_core
  import art_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [TypeW-1:0]  pkt_type_i,
  input  logic [StampW-1:0] pkt_stamp_i,
  input  logic [PeerW-1:0]  peer_addr_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_kind_o,
  output logic [TypeW-1:0]  out_type_o,
  output logic [StampW-1:0] out_stamp_o,
  output logic [PeerW-1:0]  out_peer_o,
  output logic [SlotW-1:0]  out_slot_o,
  output logic              last_o,
  // resend interval register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [AgeW-1:0]   cfg_data_i
);

  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    StIdle,
    StSend,
    StMiss,
    StSrch,
    StShift,
    StTick,
    StFlush
  } state_e;

  // sequencer and result registers
  state_e               state_q, state_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [ResCntW-1:0]   nres_q, nres_d;
  logic [AgeW-1:0]      interval_q;
  entry_t               key_q, key_d;
  result_t              pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  result_t              out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;

  // table memory
  entry_t               mem_q [TableDepth];
  entry_t               rd_q;
  logic                 mem_re, mem_we;
  logic [IdxW-1:0]      mem_raddr, mem_waddr;
  entry_t               mem_wdata;

  // scan helpers
  logic [CntW:0]        idx_x, count_x;
  logic [IdxW+3:0]      idx_wide, cnt_wide;
  logic [SlotW-1:0]     idx_slot, cnt_slot;
  logic [AgeW-1:0]      age_inc;
  logic                 due, hit, out_free, more1, more2;

  assign idx_x    = {{(CntW + 1 - IdxW){1'b0}}, idx_q};
  assign count_x  = {1'b0, count_q};
  // out_slot carries the low bits of the table position
  assign idx_wide = {4'b0000, idx_q};
  assign cnt_wide = {4'b0000, count_q[IdxW-1:0]};
  assign idx_slot = idx_wide[SlotW-1:0];
  assign cnt_slot = cnt_wide[SlotW-1:0];
  assign more1    = (idx_x + (CntW + 1)'(1)) < count_x;
  assign more2    = (idx_x + (CntW + 1)'(2)) < count_x;

  // age saturates, a zero interval makes every entry due
  assign age_inc  = (rd_q.age != AgeMax) ? rd_q.age + 16'd1 : rd_q.age;
  assign due      = (age_inc >= interval_q) && (nres_q < ResCntW'(MaxResults));
  assign hit      = (rd_q.ptype == key_q.ptype) && (rd_q.stamp == key_q.stamp)
                    && (rd_q.peer == key_q.peer);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    nres_d       = nres_q;
    key_d        = key_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_load     = 1'b0;
    out_d        = out_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          key_d.ptype = pkt_type_i;
          key_d.stamp = pkt_stamp_i;
          key_d.peer  = peer_addr_i;
          key_d.age   = '0;
          case (req_type_i)
            ReqSend: begin
              state_d = StSend;
            end
            ReqAck: begin
              if (count_q != '0) begin
                mem_re  = 1'b1;
                idx_d   = '0;
                state_d = StSrch;
              end else begin
                state_d = StMiss;
              end
            end
            ReqTick: begin
              // an empty table gives no result
              if (count_q != '0) begin
                mem_re  = 1'b1;
                idx_d   = '0;
                nres_d  = '0;
                state_d = StTick;
              end
            end
            default: begin
              // unused request code is dropped
            end
          endcase
        end
      end

      StSend: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_d.ptype = key_q.ptype;
          out_d.stamp = key_q.stamp;
          out_d.peer  = key_q.peer;
          out_d.last  = 1'b1;
          if (count_q < CntW'(TableDepth)) begin
            mem_we     = 1'b1;
            mem_waddr  = count_q[IdxW-1:0];
            mem_wdata  = key_q;
            out_d.kind = EvStored;
            out_d.slot = cnt_slot;
            count_d    = count_q + 1'b1;
          end else begin
            out_d.kind = EvFull;
            out_d.slot = '0;
          end
          state_d = StIdle;
        end
      end

      StMiss: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_d.kind  = EvMissed;
          out_d.ptype = key_q.ptype;
          out_d.stamp = key_q.stamp;
          out_d.peer  = key_q.peer;
          out_d.slot  = '0;
          out_d.last  = 1'b1;
          state_d     = StIdle;
        end
      end

      StSrch: begin
        if (hit) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_d.kind  = EvMatched;
            out_d.ptype = rd_q.ptype;
            out_d.stamp = rd_q.stamp;
            out_d.peer  = rd_q.peer;
            out_d.slot  = idx_slot;
            out_d.last  = 1'b1;
            if (more1) begin
              mem_re    = 1'b1;
              mem_raddr = idx_q + 1'b1;
              state_d   = StShift;
            end else begin
              count_d = count_q - 1'b1;
              state_d = StIdle;
            end
          end
        end else if (more1) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end else begin
          state_d = StMiss;
        end
      end

      StShift: begin
        // rd_q holds the entry above the hole at idx_q
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_q;
        if (more2) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + IdxW'(2);
          idx_d     = idx_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          state_d = StIdle;
        end
      end

      StTick: begin
        // hold while a second resend waits for the output register
        if (!(due && pend_valid_q && !out_free)) begin
          mem_we        = 1'b1;
          mem_waddr     = idx_q;
          mem_wdata     = rd_q;
          mem_wdata.age = due ? '0 : age_inc;
          if (due) begin
            if (pend_valid_q) begin
              out_load = 1'b1;
              out_d    = pend_q;
            end
            pend_d.kind  = EvResend;
            pend_d.ptype = rd_q.ptype;
            pend_d.stamp = rd_q.stamp;
            pend_d.peer  = rd_q.peer;
            pend_d.slot  = idx_slot;
            pend_d.last  = 1'b0;
            pend_valid_d = 1'b1;
            nres_d       = nres_q + 1'b1;
          end
          if (more1) begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + 1'b1;
            idx_d     = idx_q + 1'b1;
          end else begin
            state_d = StFlush;
          end
        end
      end

      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      count_q      <= '0;
      nres_q       <= '0;
      interval_q   <= IntervalReset;
      key_q        <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      nres_q       <= nres_d;
      key_q        <= key_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        interval_q <= cfg_data_i;
      end
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_q.kind;
  assign out_type_o   = out_q.ptype;
  assign out_stamp_o  = out_q.stamp;
  assign out_peer_o   = out_q.peer;
  assign out_slot_o   = out_q.slot;
  assign last_o       = out_q.last;

endmodule

// File: src/art_checker.sv
// port-level checks of the ack retransmit tracker and their bind
module art_checker
  import art_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        req_type_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [2:0]        event_kind_o,
  input logic [TypeW-1:0]  out_type_o,
  input logic [StampW-1:0] out_stamp_o,
  input logic [PeerW-1:0]  out_peer_o,
  input logic [SlotW-1:0]  out_slot_o,
  input logic              last_o,
  input logic              cfg_ready_o
);

  // a send or an ack always occupies the sequencer, so the input stalls after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o
      && (req_type_i == 2'(ReqSend) || req_type_i == 2'(ReqAck))
    |=> in_stall_o)
    else $error("send or ack accepted without busy cycle");

  // a stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(event_kind_o) && $stable(out_type_o)
        && $stable(out_stamp_o) && $stable(out_peer_o)
        && $stable(out_slot_o) && $stable(last_o))
    else $error("stalled request changed");

  // rejected sends and unmatched acks echo the request at slot zero, alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == 3'(EvFull) || event_kind_o == 3'(EvMissed))
    |-> out_slot_o == '0 && last_o)
    else $error("bad full or miss request");

  // stored and matched are the only request of their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == 3'(EvStored) || event_kind_o == 3'(EvMatched))
    |-> last_o)
    else $error("single request without last");

  // the interval register opens only while the item channel is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("interval write possible while busy");

endmodule

bind ack_retransmit_tracker_core art_checker u_art_checker (.*);

// File: sim/tb_ack_retransmit_tracker_core.sv
`timescale 1ns / 1ps
// testbench of the ack retransmit tracker core: directed and random request traffic checked against a table model
module tb_ack_retransmit_tracker_core;
  import art_pkg::*;

  localparam int Depth        = TableDepthDefault;
  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 40;
  localparam int ShowMax      = 10;
  localparam int PhaseLen     = 65;

  // request code the block accepts and discards
  localparam logic [1:0] ReqIgnored = 2'd3;

  typedef struct packed {
    logic [1:0]        req;
    logic [TypeW-1:0]  ptype;
    logic [StampW-1:0] stamp;
    logic [PeerW-1:0]  peer;
  } request_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic [TypeW-1:0]  pkt_type_i;
  logic [StampW-1:0] pkt_stamp_i;
  logic [PeerW-1:0]  peer_addr_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [2:0]        event_kind_o;
  logic [TypeW-1:0]  out_type_o;
  logic [StampW-1:0] out_stamp_o;
  logic [PeerW-1:0]  out_peer_o;
  logic [SlotW-1:0]  out_slot_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [AgeW-1:0]   cfg_data_i;

  ack_retransmit_tracker_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .pkt_type_i  (pkt_type_i),
    .pkt_stamp_i (pkt_stamp_i),
    .peer_addr_i (peer_addr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_kind_o(event_kind_o),
    .out_type_o  (out_type_o),
    .out_stamp_o (out_stamp_o),
    .out_peer_o  (out_peer_o),
    .out_slot_o  (out_slot_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the retransmit table
  logic [TypeW-1:0]  tbl_type  [Depth];
  logic [StampW-1:0] tbl_stamp [Depth];
  logic [PeerW-1:0]  tbl_peer  [Depth];
  logic [AgeW-1:0]   tbl_age   [Depth];
  int                tbl_count;
  logic [AgeW-1:0]   resend_ival;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  request_t live_sent[$];

  int   queued_cnt;
  int   accepted_cnt;
  int   mismatches;
  int   cycle_cnt;
  int   send_gap;
  int   stall_left;
  int   calm_left;
  logic in_taken;
  result_t want;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t make_result(input event_e kind, input logic [TypeW-1:0] t,
                                          input logic [StampW-1:0] s,
                                          input logic [PeerW-1:0] p, input int slot);
    result_t r;
    r.kind  = kind;
    r.ptype = t;
    r.stamp = s;
    r.peer  = p;
    r.slot  = SlotW'(slot);
    r.last  = 1'b0;
    return r;
  endfunction

  // apply one accepted request to the shadow table and queue what it must produce
  task automatic track_request(input request_t rq);
    result_t res [MaxResults];
    result_t r;
    int      n;
    int      hit;
    n = 0;
    case (rq.req)
      ReqSend: begin
        if (tbl_count < Depth) begin
          tbl_type[tbl_count]  = rq.ptype;
          tbl_stamp[tbl_count] = rq.stamp;
          tbl_peer[tbl_count]  = rq.peer;
          tbl_age[tbl_count]   = '0;
          res[0] = make_result(EvStored, rq.ptype, rq.stamp, rq.peer, tbl_count);
          tbl_count++;
        end else begin
          res[0] = make_result(EvFull, rq.ptype, rq.stamp, rq.peer, 0);
        end
        n = 1;
      end
      ReqAck: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_type[i] == rq.ptype && tbl_stamp[i] == rq.stamp &&
              tbl_peer[i] == rq.peer)
            hit = i;
        end
        if (hit >= 0) begin
          res[0] = make_result(EvMatched, tbl_type[hit], tbl_stamp[hit], tbl_peer[hit], hit);
          // later entries close the gap
          for (int j = hit; j + 1 < tbl_count; j++) begin
            tbl_type[j]  = tbl_type[j+1];
            tbl_stamp[j] = tbl_stamp[j+1];
            tbl_peer[j]  = tbl_peer[j+1];
            tbl_age[j]   = tbl_age[j+1];
          end
          tbl_count--;
        end else begin
          res[0] = make_result(EvMissed, rq.ptype, rq.stamp, rq.peer, 0);
        end
        n = 1;
      end
      ReqTick: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_age[i] < AgeMax)
            tbl_age[i] = tbl_age[i] + 1'b1;
          if (tbl_age[i] >= resend_ival && n < MaxResults) begin
            res[n] = make_result(EvResend, tbl_type[i], tbl_stamp[i], tbl_peer[i], i);
            tbl_age[i] = '0;
            n++;
          end
        end
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      r = res[k];
      r.last = (k == n - 1);
      expected_results.push_back(r);
    end
  endtask

  // idle length for either side, mostly none, a few long ones
  function automatic int idle_len();
    int roll;
    if (calm_left > 0)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      return 0;
    if (roll < 96)
      return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic request_t rand_req(input logic [1:0] kind);
    request_t rq;
    rq.req   = kind;
    rq.ptype = 8'($urandom);
    rq.stamp = {$urandom, $urandom};
    rq.peer  = {16'($urandom), $urandom};
    return rq;
  endfunction

  task automatic queue_req(input request_t rq);
    pending_reqs.push_back(rq);
    queued_cnt++;
  endtask

  // every request taken and every result seen, then let a silent tick finish
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_interval(input logic [AgeW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    resend_ival = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed traffic: sends, acks of live sends, ticks; some near misses and junk
  task automatic fill_random(input int n);
    request_t       rq;
    logic [119:0]   key;
    int             roll;
    int             pick;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      rq = rand_req(ReqSend);
      if (roll < 36) begin
        if (live_sent.size() > 0 && $urandom_range(0, 9) == 0)
          rq = live_sent[$urandom_range(0, live_sent.size() - 1)];
        rq.req = ReqSend;
        live_sent.push_back(rq);
        if (live_sent.size() > 24)
          void'(live_sent.pop_front());
      end else if (roll < 62) begin
        if (live_sent.size() > 0) begin
          pick = $urandom_range(0, live_sent.size() - 1);
          rq = live_sent[pick];
          live_sent.delete(pick);
        end
        rq.req = ReqAck;
      end else if (roll < 68) begin
        // ack that differs from a live send in one bit
        if (live_sent.size() > 0)
          rq = live_sent[$urandom_range(0, live_sent.size() - 1)];
        key = {rq.ptype, rq.stamp, rq.peer};
        pick = $urandom_range(0, 119);
        key[pick] = ~key[pick];
        {rq.ptype, rq.stamp, rq.peer} = key;
        rq.req = ReqAck;
      end else if (roll < 97) begin
        rq.req = ReqTick;
      end else begin
        rq.req = ReqIgnored;
      end
      queue_req(rq);
    end
  endtask

  // input side: note each accepted request and predict its results
  always @(posedge clk_i) begin : in_accept
    request_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen = {req_type_i, pkt_type_i, pkt_stamp_i, peer_addr_i};
      track_request(seen);
      accepted_cnt++;
      in_taken = 1'b1;
    end
  end

  // request driver, fed from the pending queue
  always @(negedge clk_i) begin : req_driver
    request_t nxt;
    if (rst_ni && (in_taken || !in_valid_i)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        req_type_i  <= nxt.req;
        pkt_type_i  <= nxt.ptype;
        pkt_stamp_i <= nxt.stamp;
        peer_addr_i <= nxt.peer;
        in_valid_i  <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result back-pressure, with calm stretches of no idling on either side
  always @(negedge clk_i) begin
    if (calm_left > 0)
      calm_left--;
    else if ($urandom_range(0, 299) == 0)
      calm_left = $urandom_range(60, 200);
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = idle_len();
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        if (mismatches < ShowMax)
          $display("cycle %0d: result with nothing pending, kind %0d slot %0d",
                   cycle_cnt, event_kind_o, out_slot_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (event_kind_o !== want.kind || out_type_o !== want.ptype ||
            out_stamp_o !== want.stamp || out_peer_o !== want.peer ||
            out_slot_o !== want.slot || last_o !== want.last) begin
          if (mismatches < ShowMax) begin
            $write("cycle %0d got/want: kind %0d/%0d type %h/%h stamp %h/%h ",
                   cycle_cnt, event_kind_o, want.kind, out_type_o, want.ptype,
                   out_stamp_o, want.stamp);
            $display("peer %h/%h slot %0d/%0d last %0d/%0d",
                     out_peer_o, want.peer, out_slot_o, want.slot, last_o, want.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("ack_retransmit_tracker_core test failed");
      $finish;
    end
  end

  initial begin
    request_t     tail;
    logic [AgeW-1:0] plan [6];
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = ReqSend;
    pkt_type_i   = '0;
    pkt_stamp_i  = '0;
    peer_addr_i  = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    in_taken     = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    calm_left    = 0;
    queued_cnt   = 0;
    accepted_cnt = 0;
    mismatches   = 0;
    cycle_cnt    = 0;
    tbl_count    = 0;
    resend_ival  = IntervalReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, duplicate sends, ignored code, partial-match ack
    queue_req({ReqSend, 8'h00, 64'd0, 48'd0});
    queue_req({ReqSend, 8'hFF, {64{1'b1}}, {48{1'b1}}});
    queue_req({ReqSend, 8'h5A, 64'h0123_4567_89AB_CDEF, 48'hC0A8_0001_1F90});
    queue_req({ReqSend, 8'h5A, 64'h0123_4567_89AB_CDEF, 48'hC0A8_0001_1F90});
    queue_req({ReqIgnored, 8'h5A, 64'h0123_4567_89AB_CDEF, 48'hC0A8_0001_1F90});
    queue_req({ReqAck, 8'hFF, {64{1'b1}}, 48'd0});
    // first of the two duplicates goes, the second shifts down
    queue_req({ReqAck, 8'h5A, 64'h0123_4567_89AB_CDEF, 48'hC0A8_0001_1F90});
    queue_req({ReqAck, 8'h00, 64'd0, 48'd0});
    // young entries, nothing due
    queue_req(rand_req(ReqTick));
    // fill the table, then one request past full
    for (int k = 0; k < 14; k++) begin
      tail = rand_req(ReqSend);
      queue_req(tail);
    end
    queue_req(rand_req(ReqSend));
    wait_drained();

    // full table all due at once, shortest interval then zero interval
    write_interval(16'd1);
    queue_req(rand_req(ReqTick));
    wait_drained();
    write_interval(16'd0);
    queue_req(rand_req(ReqTick));
    queue_req({ReqAck, 8'hFF, {64{1'b1}}, {48{1'b1}}});
    tail.req = ReqAck;
    queue_req(tail);
    wait_drained();

    plan[0] = IntervalReset;
    plan[1] = 16'd3;
    plan[2] = AgeMax;
    plan[3] = 16'd1;
    plan[4] = 16'($urandom_range(2, 40));
    plan[5] = 16'd0;
    for (int p = 0; p < 6; p++) begin
      write_interval(plan[p]);
      queue_req(rand_req(ReqTick));
      fill_random(PhaseLen);
      wait_drained();
    end

    if (mismatches == 0)
      $display("ack_retransmit_tracker_core test passed");
    else
      $display("ack_retransmit_tracker_core test failed");
    $finish;
  end

endmodule
